// ===== rtl/mcs_pkg.sv =====
package mcs_pkg;

  // Width of every numeric field on the ports
  localparam int PORT_W = 32;

  typedef struct packed {
    logic signed [PORT_W-1:0] a_c0_r0;
    logic signed [PORT_W-1:0] a_c0_r1;
    logic signed [PORT_W-1:0] a_c1_r0;
    logic signed [PORT_W-1:0] a_c1_r1;
    logic signed [PORT_W-1:0] rhs_0;
    logic signed [PORT_W-1:0] rhs_1;
  } req_t;

  typedef struct packed {
    logic signed [PORT_W-1:0] sol_0;
    logic signed [PORT_W-1:0] sol_1;
    logic                     solvable;
    logic                     saturated;
  } rsp_t;

  // Per-request status that rides alongside the divider data
  typedef struct packed {
    logic zero;      // determinant is exactly zero
    logic den_neg;   // determinant is negative
    logic num0_neg;  // numerator of sol_0 is negative
    logic num1_neg;  // numerator of sol_1 is negative
    logic ovf0;      // quotient 0 too large for the divider window
    logic ovf1;      // quotient 1 too large for the divider window
  } flags_t;

endpackage

// ===== rtl/mcs_front.sv =====
module mcs_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  mcs_pkg::req_t                 req,
  output logic                          out_valid,
  output mcs_pkg::flags_t               out_flags,
  output logic [2*DATA_WIDTH-1:0]       out_dm,
  output logic [2*DATA_WIDTH-1:0]       out_rem0,
  output logic [2*DATA_WIDTH-1:0]       out_rem1,
  output logic [DATA_WIDTH:0]           out_low0,
  output logic [DATA_WIDTH:0]           out_low1
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW;
  localparam int XW = PW + FRAC_BITS;
  localparam int QW = DW + 1;

  // Low DATA_WIDTH bits of each element, sign extended by the signed type
  logic signed [DW-1:0] a00, a01, a10, a11, b0, b1;

  assign a00 = $signed(req.a_c0_r0[DW-1:0]);
  assign a01 = $signed(req.a_c0_r1[DW-1:0]);
  assign a10 = $signed(req.a_c1_r0[DW-1:0]);
  assign a11 = $signed(req.a_c1_r1[DW-1:0]);
  assign b0  = $signed(req.rhs_0[DW-1:0]);
  assign b1  = $signed(req.rhs_1[DW-1:0]);

  // Stage 1: six products
  logic                 s1_valid;
  logic signed [PW-1:0] p_a00a11, p_a10a01, p_b0a11, p_a10b1, p_a00b1, p_b0a01;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a00a11 <= a00 * a11;
      p_a10a01 <= a10 * a01;
      p_b0a11  <= b0 * a11;
      p_a10b1  <= a10 * b1;
      p_a00b1  <= a00 * b1;
      p_b0a01  <= b0 * a01;
    end
  end

  // Stage 2: differences as sign and magnitude
  logic          den_neg_c, num0_neg_c, num1_neg_c;
  logic [PW-1:0] den_pq, den_qp, num0_pq, num0_qp, num1_pq, num1_qp;

  always_comb begin
    den_neg_c  = p_a00a11 < p_a10a01;
    num0_neg_c = p_b0a11 < p_a10b1;
    num1_neg_c = p_a00b1 < p_b0a01;
    den_pq     = p_a00a11 - p_a10a01;
    den_qp     = p_a10a01 - p_a00a11;
    num0_pq    = p_b0a11 - p_a10b1;
    num0_qp    = p_a10b1 - p_b0a11;
    num1_pq    = p_a00b1 - p_b0a01;
    num1_qp    = p_b0a01 - p_a00b1;
  end

  logic          s2_valid;
  logic          den_neg, num0_neg, num1_neg;
  logic [PW-1:0] den_mag, num0_mag, num1_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_neg  <= den_neg_c;
      num0_neg <= num0_neg_c;
      num1_neg <= num1_neg_c;
      den_mag  <= den_neg_c ? den_qp : den_pq;
      num0_mag <= num0_neg_c ? num0_qp : num0_pq;
      num1_mag <= num1_neg_c ? num1_qp : num1_pq;
    end
  end

  // Stage 3: scale numerators and split off the part above the quotient window.
  // If that upper part already reaches the divisor, the quotient needs more
  // than DATA_WIDTH+1 bits and will saturate.
  logic [XW-1:0] x0, x1, hi0, hi1;

  always_comb begin
    x0  = XW'(num0_mag) << FRAC_BITS;
    x1  = XW'(num1_mag) << FRAC_BITS;
    hi0 = x0 >> QW;
    hi1 = x1 >> QW;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags.zero     <= den_mag == '0;
      out_flags.den_neg  <= den_neg;
      out_flags.num0_neg <= num0_neg;
      out_flags.num1_neg <= num1_neg;
      out_flags.ovf0     <= hi0 >= XW'(den_mag);
      out_flags.ovf1     <= hi1 >= XW'(den_mag);
      out_dm             <= den_mag;
      out_rem0           <= hi0[PW-1:0];
      out_rem1           <= hi1[PW-1:0];
      out_low0           <= x0[QW-1:0];
      out_low1           <= x1[QW-1:0];
    end
  end

endmodule

// ===== rtl/mcs_div_step.sv =====
module mcs_div_step #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  mcs_pkg::flags_t         in_flags,
  input  logic [2*DATA_WIDTH-1:0] in_dm,
  input  logic [2*DATA_WIDTH-1:0] in_rem0,
  input  logic [2*DATA_WIDTH-1:0] in_rem1,
  input  logic [DATA_WIDTH:0]     in_low0,
  input  logic [DATA_WIDTH:0]     in_low1,
  input  logic [DATA_WIDTH:0]     in_q0,
  input  logic [DATA_WIDTH:0]     in_q1,
  output logic                    out_valid,
  output mcs_pkg::flags_t         out_flags,
  output logic [2*DATA_WIDTH-1:0] out_dm,
  output logic [2*DATA_WIDTH-1:0] out_rem0,
  output logic [2*DATA_WIDTH-1:0] out_rem1,
  output logic [DATA_WIDTH:0]     out_low0,
  output logic [DATA_WIDTH:0]     out_low1,
  output logic [DATA_WIDTH:0]     out_q0,
  output logic [DATA_WIDTH:0]     out_q1
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int QW = DATA_WIDTH + 1;

  // One restoring step per numerator: shift in the next dividend bit,
  // subtract the divisor when it fits
  logic [PW:0] r0, r1, dm_x, rn0, rn1;
  logic        ge0, ge1;

  always_comb begin
    dm_x = {1'b0, in_dm};
    r0   = {in_rem0, in_low0[QW-1]};
    r1   = {in_rem1, in_low1[QW-1]};
    ge0  = r0 >= dm_x;
    ge1  = r1 >= dm_x;
    rn0  = ge0 ? r0 - dm_x : r0;
    rn1  = ge1 ? r1 - dm_x : r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags <= in_flags;
      out_dm    <= in_dm;
      out_rem0  <= rn0[PW-1:0];
      out_rem1  <= rn1[PW-1:0];
      out_low0  <= {in_low0[QW-2:0], 1'b0};
      out_low1  <= {in_low1[QW-2:0], 1'b0};
      out_q0    <= {in_q0[QW-2:0], ge0};
      out_q1    <= {in_q1[QW-2:0], ge1};
    end
  end

endmodule

// ===== rtl/mat2_cramer_solve_unit.sv =====
// 2x2 linear solver by Cramer's rule, signed fixed point.
//
// Request channel (req_valid / req_ready / req): matrix A, column-major, and
// right-hand side b, each DATA_WIDTH bits with FRAC_BITS fraction bits in the
// low bits of the 32-bit fields. Response channel (rsp_valid / rsp_ready /
// rsp): sol_0, sol_1 in the same format (zero extended above DATA_WIDTH),
// solvable (determinant nonzero) and saturated (a quotient was clamped).
// A singular matrix returns all-zero fields.
//
// From request to response a result passes the product, difference and divider
// setup stages, the DATA_WIDTH + 1 restoring divider steps, one quotient bit per
// step, and the output register. One request is taken per cycle while req_ready
// is high; each divider step is a single registered subtract-and-compare, so a
// new request can enter every cycle while the pipeline advances.
//
// Reset clears all valid bits; in-flight requests are dropped. When the
// receiver stalls, the output register holds its response and the pipeline
// keeps taking requests until its last stage is also full; only then does
// req_ready drop.
module mat2_cramer_solve_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mcs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mcs_pkg::rsp_t rsp
);

  localparam int DW    = DATA_WIDTH;
  localparam int PW    = 2 * DW;
  localparam int QW    = DW + 1;
  localparam int OUT_W = mcs_pkg::PORT_W;

  // Largest magnitudes a result may carry, as QW-bit values
  localparam logic [QW-1:0] HALF_Q = {2'b01, {(DW-1){1'b0}}};
  localparam logic [QW-1:0] MAXP_Q = {2'b00, {(DW-1){1'b1}}};

  // Pipeline stage signals; index 0 is the divider setup stage,
  // index QW the last divider step
  logic            v_s     [0:QW];
  mcs_pkg::flags_t flags_s [0:QW];
  logic [PW-1:0]   dm_s    [0:QW];
  logic [PW-1:0]   rem0_s  [0:QW];
  logic [PW-1:0]   rem1_s  [0:QW];
  logic [QW-1:0]   low0_s  [0:QW];
  logic [QW-1:0]   low1_s  [0:QW];
  logic [QW-1:0]   q0_s    [0:QW];
  logic [QW-1:0]   q1_s    [0:QW];

  // Advance the whole pipeline unless its last stage holds a result that
  // cannot move into a stalled output register
  logic en;
  logic load;

  assign en        = !(v_s[QW] && rsp_valid && !rsp_ready);
  assign load      = v_s[QW] && en;
  assign req_ready = en;

  mcs_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .req       (req),
    .out_valid (v_s[0]),
    .out_flags (flags_s[0]),
    .out_dm    (dm_s[0]),
    .out_rem0  (rem0_s[0]),
    .out_rem1  (rem1_s[0]),
    .out_low0  (low0_s[0]),
    .out_low1  (low1_s[0])
  );

  // The quotient accumulates from an empty register
  assign q0_s[0] = '0;
  assign q1_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_step
    mcs_div_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_s[k]),
      .in_flags  (flags_s[k]),
      .in_dm     (dm_s[k]),
      .in_rem0   (rem0_s[k]),
      .in_rem1   (rem1_s[k]),
      .in_low0   (low0_s[k]),
      .in_low1   (low1_s[k]),
      .in_q0     (q0_s[k]),
      .in_q1     (q1_s[k]),
      .out_valid (v_s[k+1]),
      .out_flags (flags_s[k+1]),
      .out_dm    (dm_s[k+1]),
      .out_rem0  (rem0_s[k+1]),
      .out_rem1  (rem1_s[k+1]),
      .out_low0  (low0_s[k+1]),
      .out_low1  (low1_s[k+1]),
      .out_q0    (q0_s[k+1]),
      .out_q1    (q1_s[k+1])
    );
  end

  // Apply the sign and clamp to the signed range. Returns {saturated, value}.
  function automatic logic [DW:0] fmt(input logic [QW-1:0] q, input logic ovf,
                                      input logic neg);
    logic [QW-1:0] mag;
    logic          sat;
    if (neg) begin
      sat = ovf || (q > HALF_Q);
      mag = sat ? HALF_Q : q;
      mag = ~mag + 1'b1;
    end else begin
      sat = ovf || (q > MAXP_Q);
      mag = sat ? MAXP_Q : q;
    end
    return {sat, mag[DW-1:0]};
  endfunction

  logic [DW:0]   res0, res1;
  logic          neg0, neg1;
  mcs_pkg::rsp_t rsp_next;

  always_comb begin
    neg0 = flags_s[QW].num0_neg ^ flags_s[QW].den_neg;
    neg1 = flags_s[QW].num1_neg ^ flags_s[QW].den_neg;
    res0 = fmt(q0_s[QW], flags_s[QW].ovf0, neg0);
    res1 = fmt(q1_s[QW], flags_s[QW].ovf1, neg1);
    if (flags_s[QW].zero) begin
      // Singular matrix: no solution, all fields zero
      rsp_next = '0;
    end else begin
      rsp_next.sol_0     = OUT_W'(res0[DW-1:0]);
      rsp_next.sol_1     = OUT_W'(res1[DW-1:0]);
      rsp_next.solvable  = 1'b1;
      rsp_next.saturated = res0[DW] | res1[DW];
    end
  end

  // Output register: hold while stalled, refill from the last divider step
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/mcs_checker.sv =====
module mcs_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input mcs_pkg::rsp_t rsp
);

  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp))
    else $error("response payload changed while stalled");

  // Backpressure reaches the request side only through a stalled output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request side stalled without output backpressure");

  // A singular system reports zero solution and no saturation
  a_singular: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.solvable |-> rsp.sol_0 == '0 && rsp.sol_1 == '0 && !rsp.saturated)
    else $error("singular response carries nonzero fields");

  // Reset leaves no response pending
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind mat2_cramer_solve_unit mcs_checker u_mcs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
